[hdl/deqi_pkg.sv]
// Shared types, codes and default sizes for the indexed double-ended queue.
package deqi_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int DEFAULT_DATA_WIDTH = 32;

    localparam int CMD_W = 2;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_FRONT = 2'd0,
        CMD_ADD_BACK  = 2'd1,
        CMD_READ      = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

endpackage

[hdl/deqi_ctrl.sv]
// Controller state machine that sequences one command through the datapath.
module deqi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output deqi_pkg::ctl_cmd_t ctl
);
    import deqi_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        ctl.load  = 1'b0;
        ctl.exec  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
            end
            S_RESP:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[hdl/deqi_dpath.sv]
// Datapath: ring memory, head pointer, count, end values and result registers.
module deqi_dpath #(
    parameter int DEPTH = deqi_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = deqi_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  deqi_pkg::ctl_cmd_t              ctl,
    input  logic [deqi_pkg::CMD_W-1:0]      cmd,
    input  logic signed [deqi_pkg::VALUE_W-1:0] value,
    input  logic [deqi_pkg::INDEX_W-1:0]    index,
    output logic signed [deqi_pkg::VALUE_W-1:0] read_data,
    output logic [deqi_pkg::STATUS_W-1:0]   status,
    output logic [deqi_pkg::COUNT_W-1:0]    count,
    output logic signed [deqi_pkg::VALUE_W-1:0] front_value,
    output logic signed [deqi_pkg::VALUE_W-1:0] back_value
);
    import deqi_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((AW > INDEX_W) ? AW : INDEX_W) + 2;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [CMD_W-1:0]      cmd_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [CW-1:0]         count_reg;
    logic [DATA_WIDTH-1:0] front_reg;
    logic [DATA_WIDTH-1:0] back_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic                  rd_ok_reg;
    logic                  rd_ok_next;
    status_t               status_reg;
    status_t               status_next;

    logic                  full;
    logic                  empty;
    logic                  is_push;
    logic                  push_ok;
    logic [DATA_WIDTH-1:0] store_word;
    logic [SW-1:0]         rd_sum;
    logic [SW-1:0]         back_sum;
    logic [AW-1:0]         rd_slot;
    logic [AW-1:0]         back_slot;
    logic [AW-1:0]         wr_slot;

    function automatic logic [VALUE_W-1:0] fit_word(input logic [DATA_WIDTH-1:0] w);
        logic signed [63:0] ext;
        ext = 64'($signed(w));
        return ext[VALUE_W-1:0];
    endfunction

    assign full       = (count_reg == CW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign is_push    = (cmd_reg == CMD_ADD_FRONT) || (cmd_reg == CMD_ADD_BACK);
    assign push_ok    = is_push && !full;
    assign store_word = DATA_WIDTH'(64'(value_reg));

    assign rd_sum    = SW'(head_reg) + SW'(index_reg);
    assign back_sum  = SW'(head_reg) + SW'(count_reg);
    assign rd_slot   = (rd_sum >= SW'(DEPTH)) ? AW'(rd_sum - SW'(DEPTH)) : AW'(rd_sum);
    assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
    assign head_next = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign wr_slot   = (cmd_reg == CMD_ADD_FRONT) ? head_next : back_slot;

    always_comb
    begin
        status_next = ST_OK;
        rd_ok_next  = 1'b0;
        if (is_push && full)
        begin
            status_next = ST_FULL;
        end
        else if (cmd_reg == CMD_READ)
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else if (SW'(index_reg) >= SW'(count_reg))
            begin
                status_next = ST_RANGE;
            end
            else
            begin
                rd_ok_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd;
            value_reg <= value;
            index_reg <= index;
        end
        if (ctl.exec)
        begin
            if (push_ok)
            begin
                mem[wr_slot] <= store_word;
            end
            else
            begin
                rdata_reg <= mem[rd_slot];
            end
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            rd_ok_reg <= 1'b0;
            front_reg <= '0;
            back_reg  <= '0;
        end
        else if (ctl.exec)
        begin
            rd_ok_reg <= rd_ok_next;
            if (push_ok)
            begin
                count_reg <= count_reg + CW'(1);
                if (cmd_reg == CMD_ADD_FRONT)
                begin
                    head_reg  <= head_next;
                    front_reg <= store_word;
                    if (empty)
                    begin
                        back_reg <= store_word;
                    end
                end
                else
                begin
                    back_reg <= store_word;
                    if (empty)
                    begin
                        front_reg <= store_word;
                    end
                end
            end
        end
    end

    assign read_data   = rd_ok_reg ? fit_word(rdata_reg) : '0;
    assign status      = status_reg;
    assign count       = COUNT_W'(count_reg);
    assign front_value = empty ? '0 : fit_word(front_reg);
    assign back_value  = empty ? '0 : fit_word(back_reg);

endmodule

[hdl/double_ended_queue_indexed.sv]
// Top level of the bounded double-ended queue with indexed reads.
//
// Each transfer carries one command: push a word at the front, push a word at
// the back, or read the element at a position counted from the front. One
// command is handled at a time: it is captured at the input transfer, executed
// in the next cycle against the single-port ring memory (one write or one
// registered read), and its result is registered in the execute state, shown
// in the response state and held until the output transfer. The next command
// is taken from the cycle after the output transfer. The front and back values
// are kept in registers beside the memory, so every result reports both ends
// without extra memory reads. A push to a full queue is refused with status
// full; reads from an empty queue or past the end are flagged and return zero.
module double_ended_queue_indexed #(
    parameter int DEPTH = deqi_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = deqi_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [deqi_pkg::CMD_W-1:0]          cmd,
    input  logic signed [deqi_pkg::VALUE_W-1:0] value,
    input  logic [deqi_pkg::INDEX_W-1:0]        index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [deqi_pkg::VALUE_W-1:0] read_data,
    output logic [deqi_pkg::STATUS_W-1:0]       status,
    output logic [deqi_pkg::COUNT_W-1:0]        count,
    output logic signed [deqi_pkg::VALUE_W-1:0] front_value,
    output logic signed [deqi_pkg::VALUE_W-1:0] back_value
);
    import deqi_pkg::*;

    ctl_cmd_t ctl;

    deqi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    deqi_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cmd         (cmd),
        .value       (value),
        .index       (index),
        .read_data   (read_data),
        .status      (status),
        .count       (count),
        .front_value (front_value),
        .back_value  (back_value)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("Input and output sides are open at once.");

    a_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> in_ready)
        else $error("Block did not return to idle after an output transfer.");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (count == '0 && read_data == '0))
        else $error("Empty status reported with elements or read data.");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (count == COUNT_W'(DEPTH)))
        else $error("Full status reported while the queue is not full.");

endmodule

[bench/double_ended_queue_indexed_tb.sv]
// Self-checking testbench for the indexed double-ended queue with randomized handshakes.
module double_ended_queue_indexed_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import deqi_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam int RANDOM_CMDS = 1800;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
        bit                        wait_idle;
    } cmd_item_t;

    typedef struct {
        logic signed [VALUE_W-1:0] read_data;
        status_t                   status;
        logic [COUNT_W-1:0]        count;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
    } deq_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [CMD_W-1:0]          cmd = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic [INDEX_W-1:0]        index = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [VALUE_W-1:0] read_data;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;

    cmd_item_t   pending_cmds[$];
    deq_result_t expected_results[$];
    cmd_item_t   offered;
    int          issued_total = 0;
    int          drained_total = 0;
    int          errors = 0;
    int          total_cmds;

    int gap_left;
    int burst_left;
    int rx_cycle;
    int rx_mode;
    int hold_left;
    int holds_done;

    logic signed [VALUE_W-1:0] q_ring [DEPTH];
    logic [INDEX_W-1:0]        q_head = '0;
    logic [COUNT_W-1:0]        q_len = '0;

    double_ended_queue_indexed uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .value       (value),
        .index       (index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .status      (status),
        .count       (count),
        .front_value (front_value),
        .back_value  (back_value)
    );

    always #6 clk = ~clk;

    function automatic deq_result_t deque_execute(input cmd_item_t it);
        deq_result_t r;
        logic [INDEX_W-1:0] slot;
        r.read_data = '0;
        r.status = ST_OK;
        if (it.cmd == CMD_ADD_FRONT || it.cmd == CMD_ADD_BACK)
        begin
            if (q_len >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else if (it.cmd == CMD_ADD_FRONT)
            begin
                q_head = q_head - 1'b1;
                q_ring[q_head] = it.value;
                q_len = q_len + 1'b1;
            end
            else
            begin
                slot = q_head + q_len[INDEX_W-1:0];
                q_ring[slot] = it.value;
                q_len = q_len + 1'b1;
            end
        end
        else if (it.cmd == CMD_READ)
        begin
            if (q_len == 0)
            begin
                r.status = ST_EMPTY;
            end
            else if ({1'b0, it.index} >= q_len)
            begin
                r.status = ST_RANGE;
            end
            else
            begin
                slot = q_head + it.index;
                r.read_data = q_ring[slot];
            end
        end
        r.count = q_len;
        r.front_value = '0;
        r.back_value = '0;
        if (q_len != 0)
        begin
            slot = q_head + q_len[INDEX_W-1:0] - 1'b1;
            r.front_value = q_ring[q_head];
            r.back_value = q_ring[slot];
        end
        return r;
    endfunction

    task automatic add_cmd(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v,
                           input logic [INDEX_W-1:0] i, input bit w);
        cmd_item_t it;
        it.cmd = c;
        it.value = v;
        it.index = i;
        it.wait_idle = w;
        pending_cmds.insert(pending_cmds.size(), it);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        bit fired;
        bit keep;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
            burst_left = 1;
        end
        else
        begin
            fired = in_valid && in_ready;
            keep = in_valid && !in_ready;
            if (fired)
            begin
                expected_results.insert(expected_results.size(), deque_execute(offered));
                issued_total <= issued_total + 1;
            end
            if (!keep)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].wait_idle &&
                           issued_total + int'(fired) != drained_total))
                begin
                    offered = pending_cmds.pop_front();
                    keep = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            in_valid <= keep;
            cmd <= offered.cmd;
            value <= offered.value;
            index <= offered.index;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        deq_result_t want;
        bit rdy;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cycle = 0;
            rx_mode = 0;
            hold_left = 0;
            holds_done = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual read_data %h",
                             $time, read_data);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("count", 32'(want.count), 32'(count));
                    check_field("front_value", want.front_value, front_value);
                    check_field("back_value", want.back_value, back_value);
                end
                drained_total <= drained_total + 1;
            end
            rx_cycle++;
            if (rx_cycle % 40 == 0)
            begin
                rx_mode = $urandom_range(0, 3);
            end
            if ((holds_done == 0 && issued_total >= 400) ||
                (holds_done == 1 && issued_total >= 1400))
            begin
                hold_left = 120;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = rx_cycle[0];
                endcase
            end
            out_ready <= rdy;
        end
    end

    initial
    begin : stimulus
        int sel;
        logic [VALUE_W-1:0] v;
        add_cmd(CMD_READ, 32'h0, 4'd0, 1'b0);
        add_cmd(CMD_UNUSED, 32'h5555_aaaa, 4'd15, 1'b0);
        add_cmd(CMD_ADD_BACK, 32'h7fff_ffff, 4'd0, 1'b0);
        add_cmd(CMD_READ, 32'h0, 4'd1, 1'b0);
        add_cmd(CMD_READ, 32'h0, 4'd0, 1'b0);
        add_cmd(CMD_ADD_FRONT, 32'h8000_0000, 4'd15, 1'b0);
        add_cmd(CMD_ADD_BACK, 32'h0000_0000, 4'd0, 1'b0);
        add_cmd(CMD_ADD_FRONT, 32'hffff_ffff, 4'd0, 1'b0);
        add_cmd(CMD_READ, 32'h0, 4'd3, 1'b0);
        add_cmd(CMD_READ, 32'h0, 4'd4, 1'b0);
        for (int k = 0; k < 12; k++)
        begin
            add_cmd((k % 2 == 0) ? CMD_ADD_FRONT : CMD_ADD_BACK, $urandom, 4'd0, 1'b0);
        end
        add_cmd(CMD_ADD_FRONT, 32'h1234_5678, 4'd0, 1'b0);
        add_cmd(CMD_ADD_BACK, 32'h8765_4321, 4'd0, 1'b0);
        add_cmd(CMD_READ, 32'h0, 4'd15, 1'b0);
        add_cmd(CMD_UNUSED, 32'haaaa_5555, 4'd0, 1'b0);
        for (int k = 0; k < RANDOM_CMDS; k++)
        begin
            sel = $urandom_range(0, 19);
            case ($urandom_range(0, 7))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                default: v = $urandom;
            endcase
            add_cmd((sel < 8) ? CMD_READ :
                    (sel < 13) ? CMD_ADD_FRONT :
                    (sel < 18) ? CMD_ADD_BACK : CMD_UNUSED,
                    v, 4'($urandom_range(0, 15)), (k == 600 || k == 1300));
        end
        total_cmds = pending_cmds.size();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (issued_total == total_cmds);
        wait (drained_total == issued_total);
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/deqi_pkg.sv
hdl/deqi_ctrl.sv
hdl/deqi_dpath.sv
hdl/double_ended_queue_indexed.sv
bench/double_ended_queue_indexed_tb.sv
